[hdl/wcrs_pkg.sv]
// Shared widths, controller/datapath command and status types.
package wcrs_pkg;

  localparam int unsigned DataW  = 16;
  localparam int unsigned CfgW   = 13;
  localparam int unsigned IdxW   = 12;
  localparam int unsigned ScoreW = 63;
  localparam int unsigned TermW  = 54;

  // Commands from the sequencer to the datapath
  typedef struct packed {
    logic capture;
    logic mul_en;
    logic rd_en;
    logic sqr_en;
    logic wgt_en;
    logic acc_en;
  } cmd_t;

  // Status from the datapath to the sequencer
  typedef struct packed {
    logic out_block;
  } status_t;

  // One-hot sequencer states
  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_MUL  = 5'b00010,
    S_SQR  = 5'b00100,
    S_WGT  = 5'b01000,
    S_ACC  = 5'b10000
  } state_e;

endpackage

[hdl/wcrs_in_if.sv]
// Pixel input channel: valid, ready and the pixel fields.
interface wcrs_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] data_real;
  logic signed [15:0] data_imag;
  logic signed [15:0] prior_real;
  logic signed [15:0] prior_imag;
  logic signed [15:0] ctf_gain;
  logic        [15:0] noise_weight;
  logic               first_image;
  logic               final_image;

  modport source (output valid, data_real, data_imag, prior_real, prior_imag,
                  ctf_gain, noise_weight, first_image, final_image,
                  input ready);
  modport sink   (input valid, data_real, data_imag, prior_real, prior_imag,
                  ctf_gain, noise_weight, first_image, final_image,
                  output ready);
endinterface

[hdl/wcrs_out_if.sv]
// Result channel: valid, ready and the emitted pixel sum.
interface wcrs_out_if;
  logic        valid;
  logic        ready;
  logic [11:0] pixel_index;
  logic [62:0] score;
  logic        saturated;
  logic        last_pixel;

  modport source (output valid, pixel_index, score, saturated, last_pixel,
                  input ready);
  modport sink   (input valid, pixel_index, score, saturated, last_pixel,
                  output ready);
endinterface

[hdl/weighted_complex_residual_sum_unit.sv]
// Top level: per-pixel weighted squared complex residual accumulator.
//
//   channel   dir  handshake     payload
//   in_i      in   valid/ready   data, prior, ctf_gain, noise_weight, image flags
//   out_o     out  valid/ready   pixel_index, score, saturated, last_pixel
//   cfg       in   cfg_we_i      cfg_wdata_i = pixels_per_image
//
// Each beat is accepted in idle, then passes through the multiply, square, weight and
// accumulate steps of one shared datapath; in_i.ready is high only in idle.
// A result waits in an output register; the next beat is accepted meanwhile,
// and only a final-image beat stalls in its accumulate step while it is full.
// rst_ni is asynchronous; it clears the pixel counter and sets pixels_per_image to 1.
// The accumulator RAM is not cleared; the first image overwrites each entry.
module weighted_complex_residual_sum_unit #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_we_i,
  input  logic [wcrs_pkg::CfgW-1:0] cfg_wdata_i,
  wcrs_in_if.sink                   in_i,
  wcrs_out_if.source                out_o
);
  import wcrs_pkg::*;

  cmd_t    cmd;
  status_t status;

  wcrs_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_i.valid),
    .in_ready_o (in_i.ready),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  wcrs_dp #(
    .MAX_PIXELS (MAX_PIXELS)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .cmd_i          (cmd),
    .status_o       (status),
    .data_real_i    (in_i.data_real),
    .data_imag_i    (in_i.data_imag),
    .prior_real_i   (in_i.prior_real),
    .prior_imag_i   (in_i.prior_imag),
    .ctf_gain_i     (in_i.ctf_gain),
    .noise_weight_i (in_i.noise_weight),
    .first_image_i  (in_i.first_image),
    .final_image_i  (in_i.final_image),
    .out_valid_o    (out_o.valid),
    .out_ready_i    (out_o.ready),
    .pixel_index_o  (out_o.pixel_index),
    .score_o        (out_o.score),
    .saturated_o    (out_o.saturated),
    .last_pixel_o   (out_o.last_pixel)
  );

endmodule

[hdl/wcrs_ram.sv]
// Generic simple dual-port RAM with registered read.
module wcrs_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 4096
) (
  input  logic                                        clk_i,
  input  logic                                        we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                            wdata_i,
  input  logic                                        re_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                            rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port, holds between reads
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

[hdl/wcrs_ctrl.sv]
// Sequencer: steps one pixel beat through multiply, square, weight, accumulate.
module wcrs_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  wcrs_pkg::status_t status_i,
  output wcrs_pkg::cmd_t    cmd_o
);
  import wcrs_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE);
  assign accept     = in_valid_i && in_ready_o;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: if (in_valid_i) state_d = S_MUL;
      S_MUL:  state_d = S_SQR;
      S_SQR:  state_d = S_WGT;
      S_WGT:  state_d = S_ACC;
      S_ACC:  if (!status_i.out_block) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Commands
  always_comb begin
    cmd_o.capture = accept;
    cmd_o.mul_en  = (state_q == S_MUL);
    cmd_o.rd_en   = (state_q == S_MUL);
    cmd_o.sqr_en  = (state_q == S_SQR);
    cmd_o.wgt_en  = (state_q == S_WGT);
    cmd_o.acc_en  = (state_q == S_ACC) && !status_i.out_block;
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> state_q == S_MUL)
    else $error("accepted beat did not start the multiply step");

  a_acc_returns: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.acc_en |=> state_q == S_IDLE)
    else $error("accumulate did not return to idle");

  a_hold_blocked: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ACC) && status_i.out_block |=> state_q == S_ACC)
    else $error("accumulate left while result register was blocked");

endmodule

[hdl/wcrs_dp.sv]
// Datapath: residual arithmetic, accumulator RAM, pixel counter, result register.
module wcrs_dp #(
  parameter int unsigned MAX_PIXELS = 4096
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [wcrs_pkg::CfgW-1:0]     cfg_wdata_i,
  input  wcrs_pkg::cmd_t                cmd_i,
  output wcrs_pkg::status_t             status_o,
  input  logic signed [wcrs_pkg::DataW-1:0] data_real_i,
  input  logic signed [wcrs_pkg::DataW-1:0] data_imag_i,
  input  logic signed [wcrs_pkg::DataW-1:0] prior_real_i,
  input  logic signed [wcrs_pkg::DataW-1:0] prior_imag_i,
  input  logic signed [wcrs_pkg::DataW-1:0] ctf_gain_i,
  input  logic [wcrs_pkg::DataW-1:0]    noise_weight_i,
  input  logic                          first_image_i,
  input  logic                          final_image_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [wcrs_pkg::IdxW-1:0]     pixel_index_o,
  output logic [wcrs_pkg::ScoreW-1:0]   score_o,
  output logic                          saturated_o,
  output logic                          last_pixel_o
);
  import wcrs_pkg::*;

  localparam int unsigned PosW  = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int unsigned CntW  = $clog2(MAX_PIXELS + 1);
  localparam int unsigned CmpW0 = (CntW > CfgW) ? CntW : CfgW;
  localparam int unsigned CmpW  = (CmpW0 > IdxW) ? CmpW0 : IdxW + 1;
  localparam int unsigned WordW = ScoreW + 1;

  // Configuration and pixel counter
  logic [CfgW-1:0] cfg_q;
  logic [PosW-1:0] pos_q;
  logic [CmpW-1:0] cfg_ext, count, pos_ext, cur_pos, next_pos;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CfgW'(1);
    end else if (cfg_we_i) begin
      cfg_q <= cfg_wdata_i;
    end
  end

  // Clamp the pixel count into 1..MAX_PIXELS, wrap a stale counter to pixel 0
  always_comb begin
    cfg_ext = CmpW'(cfg_q);
    priority if (cfg_ext == '0) begin
      count = CmpW'(1);
    end else if (cfg_ext > CmpW'(MAX_PIXELS)) begin
      count = CmpW'(MAX_PIXELS);
    end else begin
      count = cfg_ext;
    end
    pos_ext  = CmpW'(pos_q);
    cur_pos  = (pos_ext >= count) ? '0 : pos_ext;
    next_pos = cur_pos + CmpW'(1);
  end

  // Captured beat
  logic signed [DataW-1:0] dr_q, di_q, pr_q, pi_q, ctf_q;
  logic [DataW-1:0]        w_q;
  logic                    first_q, final_q, last_q;
  logic [CmpW-1:0]         item_pos_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) begin
      dr_q       <= data_real_i;
      di_q       <= data_imag_i;
      pr_q       <= prior_real_i;
      pi_q       <= prior_imag_i;
      ctf_q      <= ctf_gain_i;
      w_q        <= noise_weight_i;
      first_q    <= first_image_i;
      final_q    <= final_image_i;
      item_pos_q <= cur_pos;
      last_q     <= (next_pos >= count);
    end
  end

  // Advance the pixel counter on accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
    end else if (cmd_i.acc_en) begin
      pos_q <= last_q ? '0 : PosW'(item_pos_q + CmpW'(1));
    end
  end

  // Step 1: scale the prior by the transfer factor
  logic signed [31:0] prod_r_q, prod_i_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.mul_en) begin
      prod_r_q <= 32'(ctf_q) * 32'(pr_q);
      prod_i_q <= 32'(ctf_q) * 32'(pi_q);
    end
  end

  // Step 2: round half up to Q.8, form the residual, square it
  logic signed [32:0] rnd_r, rnd_i;
  logic signed [18:0] scl_r, scl_i, res_r, res_i;
  logic signed [37:0] sqf_r, sqf_i;
  logic [36:0]        sq_r_q, sq_i_q;

  always_comb begin
    rnd_r = 33'(prod_r_q) + 33'sd8192;
    rnd_i = 33'(prod_i_q) + 33'sd8192;
    scl_r = 19'(rnd_r >>> 14);
    scl_i = 19'(rnd_i >>> 14);
    res_r = 19'(dr_q) - scl_r;
    res_i = 19'(di_q) - scl_i;
    sqf_r = 38'(res_r) * 38'(res_r);
    sqf_i = 38'(res_i) * 38'(res_i);
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.sqr_en) begin
      sq_r_q <= sqf_r[36:0];
      sq_i_q <= sqf_i[36:0];
    end
  end

  // Step 3: weight the squared magnitude
  logic [37:0]      mag;
  logic [TermW-1:0] term_q;
  assign mag = 38'(sq_r_q) + 38'(sq_i_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.wgt_en) begin
      term_q <= TermW'(mag) * TermW'(w_q);
    end
  end

  // Accumulator store: {saturation mark, sum}
  logic [WordW-1:0] rd_word, wr_word;
  logic [63:0]      sum_wide;
  logic [ScoreW-1:0] sum;
  logic             sat;

  wcrs_ram #(
    .Width (WordW),
    .Depth (MAX_PIXELS)
  ) u_acc_ram (
    .clk_i   (clk_i),
    .we_i    (cmd_i.acc_en),
    .waddr_i (PosW'(item_pos_q)),
    .wdata_i (wr_word),
    .re_i    (cmd_i.rd_en),
    .raddr_i (PosW'(item_pos_q)),
    .rdata_o (rd_word)
  );

  // Step 4: overwrite on the first image, else add with saturation
  always_comb begin
    sum_wide = 64'(rd_word[ScoreW-1:0]) + 64'(term_q);
    priority if (first_q) begin
      sum = ScoreW'(term_q);
      sat = 1'b0;
    end else if (sum_wide[63]) begin
      sum = '1;
      sat = 1'b1;
    end else begin
      sum = sum_wide[ScoreW-1:0];
      sat = rd_word[ScoreW];
    end
    wr_word = {sat, sum};
  end

  // Result register, parts the output side from the sequencer
  logic              out_valid_q;
  logic [IdxW-1:0]   idx_q;
  logic [ScoreW-1:0] score_q;
  logic              sat_q, last_out_q;
  logic              load_out;

  assign load_out = cmd_i.acc_en && final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      idx_q      <= item_pos_q[IdxW-1:0];
      score_q    <= sum;
      sat_q      <= sat;
      last_out_q <= last_q;
    end
  end

  assign status_o.out_block = final_q && out_valid_q && !out_ready_i;
  assign out_valid_o   = out_valid_q;
  assign pixel_index_o = idx_q;
  assign score_o       = score_q;
  assign saturated_o   = sat_q;
  assign last_pixel_o  = last_out_q;

  a_rise_from_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(cmd_i.acc_en && final_q))
    else $error("result appeared without a final-image accumulate");

  a_pos_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.acc_en |=> CmpW'(pos_q) < count)
    else $error("pixel counter advanced beyond the pixel count");

  a_result_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && !out_ready_i |=> out_valid_q && $stable(idx_q) && $stable(score_q))
    else $error("waiting result changed before it was taken");

endmodule

[bench/tb_weighted_complex_residual_sum_unit.sv]
`timescale 1ns / 1ps
// Testbench for the per-pixel weighted complex residual sum unit with a scoreboard class.
module tb_weighted_complex_residual_sum_unit;
  import wcrs_pkg::*;

  localparam int unsigned DEPTH         = 4096;
  localparam int unsigned RANDOM_PIXELS = 1400;
  localparam int unsigned SETTLE_CYCLES = 12;
  localparam int unsigned HOLD_CYCLES   = 300;
  localparam int unsigned TIMEOUT_NS    = 20_000_000;
  localparam logic [63:0] SCORE_MAX     = 64'h7FFF_FFFF_FFFF_FFFF;

  typedef struct {
    logic signed [DataW-1:0] data_real;
    logic signed [DataW-1:0] data_imag;
    logic signed [DataW-1:0] prior_real;
    logic signed [DataW-1:0] prior_imag;
    logic signed [DataW-1:0] ctf_gain;
    logic        [DataW-1:0] noise_weight;
    logic                    first_image;
    logic                    final_image;
  } pixel_t;

  typedef struct {
    logic [IdxW-1:0]   pixel_index;
    logic [ScoreW-1:0] score;
    logic              saturated;
    logic              last_pixel;
  } pixel_sum_t;

  // Per-pixel accumulator model and queue of sums still owed by the block
  class residual_sum_scoreboard;
    logic [CfgW-1:0] pixels_per_image;
    logic [63:0]     acc_sum [DEPTH];
    bit              acc_sat [DEPTH];
    bit              acc_written [DEPTH];
    int unsigned     position;
    pixel_sum_t      expected_sums [$];
    int unsigned     mismatches;

    function new();
      pixels_per_image = 1;
      position = 0;
      mismatches = 0;
      foreach (acc_written[i]) acc_written[i] = 0;
    endfunction

    // Zero acts as one, anything above the store depth is clipped to it
    function int unsigned pixel_count();
      int unsigned n;
      n = pixels_per_image;
      if (n == 0) n = 1;
      if (n > DEPTH) n = DEPTH;
      return n;
    endfunction

    // A counter left beyond a shrunken image wraps to pixel 0
    function int unsigned next_pixel();
      return (position >= pixel_count()) ? 0 : position;
    endfunction

    function void write_config(logic [CfgW-1:0] value);
      pixels_per_image = value;
    endfunction

    // Q1.14 gain times Q7.8 prior, rounded half up back to Q7.8
    function longint scale_prior(longint gain, longint prior);
      return (gain * prior + 8192) >>> 14;
    endfunction

    function void note_input(pixel_t px);
      int unsigned pos;
      longint      gain;
      longint      res_re;
      longint      res_im;
      logic [63:0] mag;
      logic [63:0] term;
      logic [63:0] acc;
      bit          sat;
      bit          last;
      pos = next_pixel();
      gain = px.ctf_gain;
      res_re = longint'(px.data_real) - scale_prior(gain, px.prior_real);
      res_im = longint'(px.data_imag) - scale_prior(gain, px.prior_imag);
      mag = res_re * res_re + res_im * res_im;
      term = mag * px.noise_weight;
      // Overwrite on the first image, otherwise add with saturation
      if (px.first_image) begin
        acc = term;
        sat = 0;
      end else begin
        acc = acc_sum[pos];
        sat = acc_sat[pos];
        if (acc > SCORE_MAX || term > SCORE_MAX - acc) begin
          acc = SCORE_MAX;
          sat = 1;
        end else begin
          acc = acc + term;
        end
      end
      acc_sum[pos] = acc;
      acc_sat[pos] = sat;
      acc_written[pos] = 1;
      last = (pos + 1 >= pixel_count());
      position = last ? 0 : pos + 1;
      if (px.final_image)
        expected_sums.push_back('{pixel_index: pos[IdxW-1:0], score: acc[ScoreW-1:0],
                                  saturated: sat, last_pixel: last});
    endfunction

    function void flag(string msg);
      if (mismatches < 10) $display("ERROR at %0t: %s", $time, msg);
      mismatches++;
    endfunction

    function void check_result(pixel_sum_t got);
      pixel_sum_t want;
      if (expected_sums.size() == 0) begin
        flag($sformatf("unexpected sum: pixel %0d score %0h sat %0b last %0b",
                       got.pixel_index, got.score, got.saturated, got.last_pixel));
        return;
      end
      want = expected_sums.pop_front();
      if (got.pixel_index !== want.pixel_index || got.score !== want.score ||
          got.saturated !== want.saturated || got.last_pixel !== want.last_pixel)
        flag($sformatf({"expected pixel %0d score %0h sat %0b last %0b, ",
                        "got pixel %0d score %0h sat %0b last %0b"},
                       want.pixel_index, want.score, want.saturated, want.last_pixel,
                       got.pixel_index, got.score, got.saturated, got.last_pixel));
    endfunction
  endclass

  logic            clk;
  logic            rst_n;
  logic            cfg_we;
  logic [CfgW-1:0] cfg_wdata;

  wcrs_in_if  pixel_ch ();
  wcrs_out_if sum_ch ();

  weighted_complex_residual_sum_unit #(
    .MAX_PIXELS(DEPTH)
  ) dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_i       (pixel_ch),
    .out_o      (sum_ch)
  );

  residual_sum_scoreboard sb = new();
  bit          idle_on = 1;
  int unsigned hold_request = 0;
  int unsigned pixels_sent = 0;

  initial clk = 1'b0;
  always #2 clk = ~clk;

  // Mostly no gap, some short ones, a few long ones
  function int unsigned gap_length();
    int unsigned r;
    if (!idle_on) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Bias toward the field extremes and small values around zero
  function logic [15:0] rand_word();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      4, 5: return 16'($urandom_range(0, 511)) - 16'd256;
      default: return 16'($urandom);
    endcase
  endfunction

  function pixel_t make_pixel(logic [15:0] dr, logic [15:0] di, logic [15:0] pr,
                              logic [15:0] pi, logic [15:0] gain, logic [15:0] weight,
                              bit is_first, bit is_final);
    pixel_t px;
    px.data_real = dr;
    px.data_imag = di;
    px.prior_real = pr;
    px.prior_imag = pi;
    px.ctf_gain = gain;
    px.noise_weight = weight;
    px.first_image = is_first;
    px.final_image = is_final;
    return px;
  endfunction

  function pixel_t rand_pixel(bit is_first, bit is_final);
    return make_pixel(rand_word(), rand_word(), rand_word(), rand_word(), rand_word(),
                      rand_word(), is_first, is_final);
  endfunction

  // Drive one beat after a random gap; never touch an accumulator not yet written
  task automatic send_pixel(pixel_t px);
    int unsigned gap;
    gap = gap_length();
    if (!sb.acc_written[sb.next_pixel()]) px.first_image = 1;
    if (gap > 0) begin
      @(negedge clk);
      pixel_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    pixel_ch.valid = 1'b1;
    pixel_ch.data_real = px.data_real;
    pixel_ch.data_imag = px.data_imag;
    pixel_ch.prior_real = px.prior_real;
    pixel_ch.prior_imag = px.prior_imag;
    pixel_ch.ctf_gain = px.ctf_gain;
    pixel_ch.noise_weight = px.noise_weight;
    pixel_ch.first_image = px.first_image;
    pixel_ch.final_image = px.final_image;
    do @(posedge clk); while (!pixel_ch.ready);
    sb.note_input(px);
    pixels_sent++;
  endtask

  // Drop valid, wait for every owed sum, then let non-final beats retire
  task automatic drain_results();
    @(negedge clk);
    pixel_ch.valid = 1'b0;
    while (sb.expected_sums.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_pixels_per_image(logic [CfgW-1:0] value);
    @(negedge clk);
    cfg_we = 1'b1;
    cfg_wdata = value;
    @(negedge clk);
    cfg_we = 1'b0;
    sb.write_config(value);
  endtask

  // Run a set of images; well-formed sets write first, accumulate, then emit
  task automatic run_series(int unsigned images, bit well_formed);
    int unsigned pos;
    bit          is_first;
    bit          is_final;
    for (int unsigned img = 0; img < images; img++) begin
      do begin
        pos = sb.next_pixel();
        if (well_formed) begin
          is_first = (img == 0);
          is_final = (img == images - 1);
        end else begin
          is_first = ($urandom_range(0, 3) == 0);
          is_final = ($urandom_range(0, 2) == 0);
        end
        send_pixel(rand_pixel(is_first, is_final));
      end while (pos + 1 < sb.pixel_count());
    end
  endtask

  // Result side: random ready stalls, long hold-off on request, check each beat
  initial begin
    pixel_sum_t  got;
    int unsigned stall_left;
    stall_left = 0;
    sum_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        stall_left = hold_request;
        hold_request = 0;
      end
      if (stall_left > 0) begin
        sum_ch.ready = 1'b0;
        stall_left--;
      end else begin
        stall_left = gap_length();
        sum_ch.ready = (stall_left == 0);
        if (stall_left > 0) stall_left--;
      end
      @(posedge clk);
      if (rst_n && sum_ch.valid && sum_ch.ready) begin
        got.pixel_index = sum_ch.pixel_index;
        got.score = sum_ch.score;
        got.saturated = sum_ch.saturated;
        got.last_pixel = sum_ch.last_pixel;
        sb.check_result(got);
      end
    end
  end

  initial begin
    #(TIMEOUT_NS);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin
    int unsigned settings [10];
    int unsigned random_start;
    settings = '{2, 4, 1, 7, 16, 0, 3, 33, 5, 12};
    rst_n = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    pixel_ch.valid = 1'b0;
    pixel_ch.data_real = '0;
    pixel_ch.data_imag = '0;
    pixel_ch.prior_real = '0;
    pixel_ch.prior_imag = '0;
    pixel_ch.ctf_gain = '0;
    pixel_ch.noise_weight = '0;
    pixel_ch.first_image = 1'b0;
    pixel_ch.final_image = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // Directed: one pixel per image after reset
    send_pixel(make_pixel(16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0000, 1, 1));
    send_pixel(make_pixel(16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'h8000, 16'hFFFF, 1, 0));
    send_pixel(make_pixel(16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'h7FFF, 16'hFFFF, 0, 1));
    // Rounding ties go up, on both signs of the product
    send_pixel(make_pixel(16'h0000, 16'h0000, 16'h2000, 16'hE000, 16'h0001, 16'h0100, 1, 1));
    send_pixel(make_pixel(16'hFFFF, 16'hFFFF, 16'h2001, 16'hDFFF, 16'hFFFF, 16'h0001, 0, 1));
    send_pixel(make_pixel(16'h8000, 16'h7FFF, 16'h0000, 16'h0000, 16'h0000, 16'h8000, 0, 0));
    send_pixel(make_pixel(16'h0100, 16'hFF00, 16'h0100, 16'hFF00, 16'h4000, 16'hFFFF, 0, 1));

    // Zero pixel count acts as one
    drain_results();
    write_pixels_per_image(0);
    send_pixel(rand_pixel(0, 1));
    send_pixel(rand_pixel(1, 1));

    // Three-pixel image written on the first pass
    drain_results();
    write_pixels_per_image(3);
    send_pixel(rand_pixel(1, 0));
    send_pixel(rand_pixel(1, 1));
    send_pixel(rand_pixel(1, 1));

    // Oversized count, then shrink below the counter so it wraps to pixel 0
    drain_results();
    write_pixels_per_image(13'h1FFF);
    repeat (4) send_pixel(rand_pixel(1, 0));
    send_pixel(rand_pixel(1, 1));
    drain_results();
    write_pixels_per_image(2);
    send_pixel(rand_pixel(0, 1));
    send_pixel(rand_pixel(0, 1));

    // Hold the result side off while beats keep coming, so the input stalls
    drain_results();
    write_pixels_per_image(1);
    idle_on = 0;
    hold_request = HOLD_CYCLES;
    repeat (24) send_pixel(rand_pixel($urandom_range(0, 3) == 0, $urandom_range(0, 5) != 0));
    idle_on = 1;

    // Random image sets over a rotating set of image sizes
    random_start = pixels_sent;
    for (int unsigned idx = 0; pixels_sent - random_start < RANDOM_PIXELS; idx++) begin
      drain_results();
      write_pixels_per_image(CfgW'(settings[idx % 10]));
      idle_on = ($urandom_range(0, 3) != 0);
      repeat ($urandom_range(2, 4))
        run_series($urandom_range(1, 5), $urandom_range(0, 9) < 8);
    end
    idle_on = 1;

    drain_results();
    if (sb.mismatches == 0 && sb.expected_sums.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
